/* rtl/dtpq_pkg.sv */
// types and codes shared by the work queue files
// no dependencies
package dtpq_pkg;

  typedef enum logic [1:0] {
    CLS_FREE = 2'd0,
    CLS_HIGH = 2'd1,
    CLS_LOW  = 2'd2,
    CLS_BUSY = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    OP_ADD_HIGH = 2'd0,
    OP_ADD_LOW  = 2'd1,
    OP_TAKE     = 2'd2,
    OP_FINISH   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BADID = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam int KEY_W   = 31;
  localparam int STAMP_W = 32;

  typedef struct packed {
    cls_t                 cls;
    logic [KEY_W-1:0]     key;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic cls;
    logic key;
    logic stamp;
  } wr_en_t;

endpackage

/* rtl/dtpq_table.sv */
// entry table: class, key and stamp memories, one write and one registered read
// depends on dtpq_pkg
module dtpq_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                            clk,
  input  dtpq_pkg::wr_en_t                wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  wr_addr,
  input  dtpq_pkg::entry_t                wr_data,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
  output dtpq_pkg::entry_t                rd_data
);
  import dtpq_pkg::*;

  cls_t               cls_mem   [TABLE_DEPTH];
  logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
  logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.cls) cls_mem[wr_addr] <= wr_data.cls;
    if (wr_en.key) key_mem[wr_addr] <= wr_data.key;
    if (wr_en.stamp) stamp_mem[wr_addr] <= wr_data.stamp;
    rd_data.cls   <= cls_mem[rd_addr];
    rd_data.key   <= key_mem[rd_addr];
    rd_data.stamp <= stamp_mem[rd_addr];
  end

endmodule

/* rtl/dedup_two_priority_work_queue_top.sv */
// two-priority work queue with id dedup: sequencer, scan unit and result register
// depends on dtpq_pkg and dtpq_table
// an add or finish with an invalid id leaves the scan state at once; other beats scan the whole table first
// throughput: one beat at a time, set by the one-entry-a-cycle scan over the table read port
// reset: rst clears control state, then a clearing pass over the table frees every
// entry while in_ready stays low; cfg writes are taken throughout
module dedup_two_priority_work_queue_top #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] user_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [30:0] next_user,
  output logic        from_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import dtpq_pkg::*;

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam logic [IW:0] DEPTH_C = (IW+1)'(TABLE_DEPTH);

  state_t state, state_next;

  // config register
  logic [7:0] low_wait_limit;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) low_wait_limit <= 8'd64;
    else if (cfg_valid) low_wait_limit <= cfg_data;
  end

  // latched beat
  op_t              op;
  logic [KEY_W-1:0] op_key;
  logic             op_ok;

  // counters
  logic [STAMP_W-1:0] stamp_counter, stamp_counter_next;
  logic [CW-1:0]      low_count, low_count_next;

  // sweep counter, used by the clearing pass and the scan
  logic [IW:0]   rd_cnt;
  logic          pv;
  logic [IW-1:0] pidx;

  // scan results
  logic          hit_f, free_f, hi_f, lo_f;
  logic [IW-1:0] hit_idx, free_idx, hi_idx, lo_idx;
  cls_t          hit_cls;
  logic [STAMP_W-1:0] hi_age, lo_age;
  logic [KEY_W-1:0]   hi_key, lo_key;

  // table ports
  wr_en_t        wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;

  dtpq_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  // shared age unit: an entry is in one class only, so one subtract and compare serve both lists
  logic               is_wait;
  logic               sel_f;
  logic [STAMP_W-1:0] sel_age, age;
  logic               take_it;
  always_comb begin
    is_wait = (rd_data.cls == CLS_HIGH) || (rd_data.cls == CLS_LOW);
    sel_f   = (rd_data.cls == CLS_HIGH) ? hi_f : lo_f;
    sel_age = (rd_data.cls == CLS_HIGH) ? hi_age : lo_age;
    age     = stamp_counter - rd_data.stamp;
    take_it = !sel_f || (age > sel_age);
  end

  // result of the apply step
  logic [2:0]       res_status;
  logic [KEY_W-1:0] res_user;
  logic             res_high;
  logic             low_over;
  logic             can_emit;

  assign low_over = CMPW'(low_count) > CMPW'(low_wait_limit);
  assign can_emit = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next         = state;
    wr_en              = '0;
    wr_addr            = rd_cnt[IW-1:0];
    wr_data.cls        = CLS_FREE;
    wr_data.key        = op_key;
    wr_data.stamp      = stamp_counter;
    stamp_counter_next = stamp_counter;
    low_count_next     = low_count;
    res_status         = ST_OK;
    res_user           = '0;
    res_high           = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_en.cls = 1'b1;
        if (rd_cnt == DEPTH_C - 1'b1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!op_ok && op != OP_TAKE) state_next = S_APPLY;
        else if (rd_cnt == DEPTH_C && !pv) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (op != OP_TAKE && !op_ok) begin
          res_status = ST_BADID;
        end else begin
          case (op)
            OP_TAKE: begin
              if (hi_f || lo_f) begin
                wr_en.cls   = 1'b1;
                wr_data.cls = CLS_BUSY;
                wr_addr     = hi_f ? hi_idx : lo_idx;
                res_user    = hi_f ? hi_key : lo_key;
                res_high    = hi_f;
                if (!hi_f) low_count_next = low_count - 1'b1;
              end else begin
                res_status = ST_EMPTY;
              end
            end
            OP_ADD_HIGH: begin
              if (!hit_f) begin
                if (free_f) begin
                  wr_en              = '1;
                  wr_addr            = free_idx;
                  wr_data.cls        = CLS_HIGH;
                  stamp_counter_next = stamp_counter + 1'b1;
                end else begin
                  res_status = ST_FULL;
                end
              end else if (hit_cls == CLS_LOW) begin
                wr_en.cls          = 1'b1;
                wr_en.stamp        = 1'b1;
                wr_addr            = hit_idx;
                wr_data.cls        = CLS_HIGH;
                stamp_counter_next = stamp_counter + 1'b1;
                low_count_next     = low_count - 1'b1;
              end
            end
            OP_ADD_LOW: begin
              if (low_over) begin
                res_status = ST_OVER;
              end else if (!hit_f) begin
                if (free_f) begin
                  wr_en              = '1;
                  wr_addr            = free_idx;
                  wr_data.cls        = CLS_LOW;
                  stamp_counter_next = stamp_counter + 1'b1;
                  low_count_next     = low_count + 1'b1;
                end else begin
                  res_status = ST_FULL;
                end
              end
            end
            default: begin
              if (hit_f) begin
                wr_en.cls   = 1'b1;
                wr_addr     = hit_idx;
                wr_data.cls = CLS_FREE;
                if (hit_cls == CLS_LOW) low_count_next = low_count - 1'b1;
              end
            end
          endcase
        end
        if (!can_emit) begin
          // hold until the previous result beat leaves
          wr_en              = '0;
          stamp_counter_next = stamp_counter;
          low_count_next     = low_count;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // sweep counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      pv     <= 1'b0;
    end else begin
      pv <= (state == S_SCAN) && (rd_cnt != DEPTH_C);
      if (state == S_CLEAR) rd_cnt <= rd_cnt + 1'b1;
      else if (state == S_SCAN && rd_cnt != DEPTH_C) rd_cnt <= rd_cnt + 1'b1;
      else if (state == S_IDLE) rd_cnt <= '0;
    end
    pidx <= rd_cnt[IW-1:0];
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op     <= op_t'(opcode);
      op_key <= user_id[30:0];
      op_ok  <= (user_id != 32'sd0) && !user_id[31];
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
      hi_f   <= 1'b0;
      lo_f   <= 1'b0;
    end else if (state == S_IDLE) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
      hi_f   <= 1'b0;
      lo_f   <= 1'b0;
    end else if (pv) begin
      if (rd_data.cls != CLS_FREE && rd_data.key == op_key && !hit_f) begin
        hit_f   <= 1'b1;
        hit_idx <= pidx;
        hit_cls <= rd_data.cls;
      end
      if (rd_data.cls == CLS_FREE && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= pidx;
      end
      if (is_wait && take_it) begin
        if (rd_data.cls == CLS_HIGH) begin
          hi_f   <= 1'b1;
          hi_idx <= pidx;
          hi_age <= age;
          hi_key <= rd_data.key;
        end else begin
          lo_f   <= 1'b1;
          lo_idx <= pidx;
          lo_age <= age;
          lo_key <= rd_data.key;
        end
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
      low_count     <= '0;
    end else begin
      stamp_counter <= stamp_counter_next;
      low_count     <= low_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_APPLY && can_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == S_APPLY && can_emit) begin
      status    <= res_status;
      next_user <= res_user;
      from_high <= res_high;
    end
  end

  // checks
  a_low_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(low_count) <= CMPW'(TABLE_DEPTH))
    else $error("low count above table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while one is in work");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("beat taken during clearing pass");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (next_user == '0 && !from_high))
    else $error("empty result carries an id");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the two-priority dedup work queue: random and directed beats,
// checked against a behavioral queue kept in the bench
// depends on dtpq_pkg and dedup_two_priority_work_queue_top
module tb;
  import dtpq_pkg::*;

  localparam int DEPTH     = 128;
  localparam int LAT       = DEPTH + 8;
  localparam int MAX_CYC   = 1_000_000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    op_t         op;
    logic [31:0] id;
  } job_t;

  typedef struct {
    logic [2:0]  status;
    logic [30:0] user;
    logic        high;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic signed [31:0] user_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [30:0] next_user;
  logic from_high;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  dedup_two_priority_work_queue_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .user_id(user_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .next_user(next_user), .from_high(from_high),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // pending jobs and answers still owed by the queue
  job_t    job_q[$];
  answer_t answer_q[$];
  int      fails = 0;
  int      cycles = 0;
  bit      steady = 1'b0;  // no idling on either side while set
  int      hold_req = 0;   // bumped to ask for one long receiver stall

  // behavioral copy of the work queue
  logic [30:0] q_key[DEPTH];
  cls_t        q_cls[DEPTH];
  logic [31:0] q_stamp[DEPTH];
  logic [31:0] stamp_ctr;
  int          high_cnt, low_cnt;
  logic [7:0]  wait_limit;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_member(logic [30:0] key);
    for (int i = 0; i < DEPTH; i++)
      if (q_cls[i] != CLS_FREE && q_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_oldest(cls_t c);
    int best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < DEPTH; i++)
      if (q_cls[i] == c) begin
        age = stamp_ctr - q_stamp[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    return best;
  endfunction

  function automatic void to_tail(int idx, cls_t c);
    q_cls[idx] = c;
    q_stamp[idx] = stamp_ctr;
    stamp_ctr = stamp_ctr + 1;
    if (c == CLS_HIGH) high_cnt++;
    else low_cnt++;
  endfunction

  function automatic logic [2:0] enqueue_new(logic [30:0] key, cls_t c);
    for (int i = 0; i < DEPTH; i++)
      if (q_cls[i] == CLS_FREE) begin
        q_key[i] = key;
        to_tail(i, c);
        return ST_OK;
      end
    return ST_FULL;
  endfunction

  // applies one job to the behavioral queue and returns the answer it owes
  function automatic answer_t queue_apply(job_t j);
    answer_t a;
    int idx;
    logic [30:0] key;
    a = '{ST_OK, '0, 1'b0};
    key = j.id[30:0];
    if (j.op == OP_TAKE) begin
      idx = find_oldest(CLS_HIGH);
      if (idx >= 0) begin
        a.high = 1'b1;
        high_cnt--;
      end else begin
        idx = find_oldest(CLS_LOW);
        if (idx >= 0) low_cnt--;
      end
      if (idx >= 0) begin
        q_cls[idx] = CLS_BUSY;
        a.user = q_key[idx];
      end else a.status = ST_EMPTY;
    end else if (j.id == 0 || j.id[31]) begin
      a.status = ST_BADID;
    end else if (j.op == OP_ADD_HIGH) begin
      idx = find_member(key);
      if (idx < 0) a.status = enqueue_new(key, CLS_HIGH);
      else if (q_cls[idx] == CLS_LOW) begin
        low_cnt--;
        to_tail(idx, CLS_HIGH);
      end
    end else if (j.op == OP_ADD_LOW) begin
      if (low_cnt > wait_limit) a.status = ST_OVER;
      else if (find_member(key) < 0) a.status = enqueue_new(key, CLS_LOW);
    end else begin
      idx = find_member(key);
      if (idx >= 0) begin
        if (q_cls[idx] == CLS_HIGH) high_cnt--;
        else if (q_cls[idx] == CLS_LOW) low_cnt--;
        q_cls[idx] = CLS_FREE;
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    fails++;
  endtask

  // driver: each job waits a random gap, then holds valid until taken
  int tx_wait = 0;
  always @(posedge clk) begin
    logic nv;
    job_t j;
    nv = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        j.op = op_t'(opcode);
        j.id = user_id;
        answer_q.insert(answer_q.size(), queue_apply(j));
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_wait > 0) tx_wait <= tx_wait - 1;
        else if (job_q.size() > 0) begin
          j = job_q[0];
          job_q.delete(0);
          opcode <= j.op;
          user_id <= j.id;
          nv = 1'b1;
          tx_wait <= steady ? 0 : $urandom_range(0, 11);
        end
      end
    end
    in_valid <= nv;
  end

  // long receiver stall, counted here on request
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor: random backpressure, each accepted beat checked against the oldest answer
  int rx_wait = 0;
  always @(posedge clk) begin
    int nw;
    answer_t a;
    nw = rx_wait;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          a = answer_q[0];
          answer_q.delete(0);
          if (status !== a.status) report_mismatch("status", status, a.status);
          if (next_user !== a.user) report_mismatch("next_user", next_user, a.user);
          if (from_high !== a.high) report_mismatch("from_high", from_high, a.high);
        end
        nw = steady ? 0 : $urandom_range(0, 11);
      end else if (nw > 0) nw--;
    end
    rx_wait <= nw;
    out_ready <= !rst && nw == 0 && hold_left == 0 && hold_seen == hold_req;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void push(op_t op, logic [31:0] id);
    job_t j;
    j.op = op;
    j.id = id;
    job_q.insert(job_q.size(), j);
  endfunction

  // random job: mostly ids from a small pool so dedup and moves happen often
  function automatic void push_random(int pool);
    op_t op;
    logic [31:0] id;
    int r;
    op = op_t'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 80) id = $urandom_range(1, pool);
    else if (r < 92) id = {1'b0, 31'($urandom)};
    else id = $urandom;
    push(op, id);
  endfunction

  // second pass covers the edge where the last job has left the list but valid is not yet up
  task automatic drain();
    repeat (2) begin
      while (job_q.size() > 0 || in_valid || answer_q.size() > 0) @(posedge clk);
      @(posedge clk);
    end
    repeat (LAT) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    wait_limit = v;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) q_cls[i] = CLS_FREE;
    stamp_ctr = '0;
    high_cnt = 0;
    low_cnt = 0;
    wait_limit = 8'd64;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: id extremes, every opcode, moves, dedup, finish cases
    push(OP_TAKE, 32'd0);
    push(OP_ADD_HIGH, 32'd0);
    push(OP_ADD_LOW, 32'hFFFF_FFFF);
    push(OP_FINISH, 32'h8000_0000);
    push(OP_ADD_HIGH, 32'h7FFF_FFFF);
    push(OP_ADD_LOW, 32'd5);
    push(OP_ADD_LOW, 32'd6);
    push(OP_ADD_LOW, 32'd5);            // already a member
    push(OP_ADD_HIGH, 32'd6);           // low to high move
    push(OP_ADD_HIGH, 32'd6);           // waiting high already
    push(OP_ADD_HIGH, 32'h5555_5555);
    push(OP_FINISH, 32'h5555_5555);     // finish while waiting
    push(OP_FINISH, 32'd99);            // not present
    push(OP_TAKE, 32'hFFFF_FFFF);
    push(OP_TAKE, 32'd0);
    push(OP_ADD_HIGH, 32'h7FFF_FFFF);   // in flight
    push(OP_TAKE, 32'd0);
    push(OP_TAKE, 32'd0);
    push(OP_FINISH, 32'h7FFF_FFFF);
    push(OP_FINISH, 32'd6);
    push(OP_FINISH, 32'd5);
    push(OP_ADD_HIGH, 32'h2AAA_AAAA);
    push(OP_TAKE, 32'd0);
    drain();

    // zero limit: second waiting low id is refused
    write_limit(8'd0);
    push(OP_ADD_LOW, 32'd10);
    push(OP_ADD_LOW, 32'd11);
    push(OP_ADD_LOW, 32'd10);
    for (int i = 0; i < 120; i++) push_random(24);
    drain();

    // top limit, fill past the table while the receiver stalls
    write_limit(8'd128);
    hold_req++;
    for (int i = 1; i <= DEPTH + 10; i++)
      push(($urandom_range(0, 1) != 0) ? OP_ADD_LOW : OP_ADD_HIGH, 32'(1000 + i));
    for (int i = 0; i < 40; i++) push(OP_TAKE, 32'd0);
    for (int i = 1; i <= DEPTH + 10; i++) push(OP_FINISH, 32'(1000 + i));
    drain();

    // random phases at assorted limits, some without idling
    for (int p = 0; p < 7; p++) begin
      write_limit((p == 3) ? 8'd1 : 8'($urandom_range(0, 128)));
      steady = (p % 3 == 1);
      for (int i = 0; i < 100; i++) push_random((p % 2 != 0) ? 16 : 200);
      drain();
      steady = 1'b0;
    end

    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/dtpq_pkg.sv
rtl/dtpq_table.sv
rtl/dedup_two_priority_work_queue_top.sv
test/tb.sv
